[rtl/smf_pkg.sv]
// shared types and constants for the spiral matrix fill block
// no dependencies; imported by the interfaces, smf_walker and spiral_order_matrix_fill

package smf_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned FieldW = 5;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    HEAD_RIGHT = 4'b0001,
    HEAD_DOWN  = 4'b0010,
    HEAD_LEFT  = 4'b0100,
    HEAD_UP    = 4'b1000
  } heading_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_COUNT    = 1'b0,
    CFG_COLUMN_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic restart;
    logic step;
  } walk_cmd_t;

  typedef struct packed {
    logic can_place;
    logic query_hit;
  } walk_status_t;

endpackage

[rtl/smf_if.sv]
// valid/ready channel interfaces: command input, result output, config write
// depends on smf_pkg

interface smf_in_if;
  import smf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [ValueW-1:0] push_value;
  logic [FieldW-1:0]        read_row;
  logic [FieldW-1:0]        read_column;

  modport source (output valid, op, push_value, read_row, read_column, input ready);
  modport sink   (input valid, op, push_value, read_row, read_column, output ready);
endinterface

interface smf_out_if;
  import smf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     placed;
  logic [FieldW-1:0]        placed_row;
  logic [FieldW-1:0]        placed_column;
  logic signed [ValueW-1:0] cell_value;

  modport source (output valid, placed, placed_row, placed_column, cell_value, input ready);
  modport sink   (input valid, placed, placed_row, placed_column, cell_value, output ready);
endinterface

interface smf_cfg_if;
  import smf_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/smf_cell_ram.sv]
// single-port-write, single-port-read cell memory with registered read data
// depends on nothing

module smf_cell_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/smf_walker.sv]
// spiral position, bounds and heading; decides whether a cell was written
// depends on smf_pkg

module smf_walker #(
  parameter int unsigned MAX_ROWS    = 32,
  parameter int unsigned MAX_COLUMNS = 32,
  parameter int unsigned PW          = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smf_pkg::walk_cmd_t            cmd_i,
  input  logic signed [PW-1:0]          rows_i,
  input  logic signed [PW-1:0]          cols_i,
  input  logic [smf_pkg::FieldW-1:0]    query_row_i,
  input  logic [smf_pkg::FieldW-1:0]    query_col_i,
  output smf_pkg::walk_status_t         status_o,
  output logic signed [PW-1:0]          cur_row_o,
  output logic signed [PW-1:0]          cur_col_o
);
  import smf_pkg::*;

  localparam logic signed [PW-1:0] MaxRowsS = PW'(MAX_ROWS);
  localparam logic signed [PW-1:0] MaxColsS = PW'(MAX_COLUMNS);
  localparam logic signed [PW-1:0] One      = PW'(1);

  logic signed [PW-1:0] top_q, top_d, bot_q, bot_d, left_q, left_d, right_q, right_d;
  logic signed [PW-1:0] row_q, row_d, col_q, col_d;
  logic signed [PW-1:0] rows_used_q, rows_used_d, cols_used_q, cols_used_d;
  heading_e             head_q, head_d;

  logic                 done, in_range;
  logic signed [PW-1:0] qr, qc;
  logic                 in_init, out_rect, on_seg;

  assign done     = (top_q > bot_q) || (left_q > right_q);
  assign in_range = (row_q >= 0) && (row_q < MaxRowsS) && (col_q >= 0) && (col_q < MaxColsS);

  // visited cells: outside the shrunken rectangle, or already passed on the current edge
  assign qr       = PW'(query_row_i);
  assign qc       = PW'(query_col_i);
  assign in_init  = (qr < rows_used_q) && (qc < cols_used_q);
  assign out_rect = (qr < top_q) || (qr > bot_q) || (qc < left_q) || (qc > right_q);

  always_comb begin
    unique case (head_q)
      HEAD_RIGHT: on_seg = (qr == top_q) && (qc >= left_q) && (qc < col_q);
      HEAD_DOWN:  on_seg = (qc == right_q) && (qr >= top_q) && (qr < row_q);
      HEAD_LEFT:  on_seg = (qr == bot_q) && (qc > col_q) && (qc <= right_q);
      default:    on_seg = (qc == left_q) && (qr > row_q) && (qr <= bot_q);
    endcase
  end

  assign status_o.can_place = !done && in_range;
  assign status_o.query_hit = in_init && (out_rect || on_seg);
  assign cur_row_o = row_q;
  assign cur_col_o = col_q;

  always_comb begin
    top_d       = top_q;
    bot_d       = bot_q;
    left_d      = left_q;
    right_d     = right_q;
    row_d       = row_q;
    col_d       = col_q;
    head_d      = head_q;
    rows_used_d = rows_used_q;
    cols_used_d = cols_used_q;
    if (cmd_i.restart) begin
      top_d       = '0;
      bot_d       = rows_i - One;
      left_d      = '0;
      right_d     = cols_i - One;
      row_d       = '0;
      col_d       = '0;
      head_d      = HEAD_RIGHT;
      rows_used_d = rows_i;
      cols_used_d = cols_i;
    end else if (cmd_i.step) begin
      unique case (head_q)
        HEAD_RIGHT: begin
          if (col_q < right_q) begin
            col_d = col_q + One;
          end else begin
            top_d  = top_q + One;
            head_d = HEAD_DOWN;
            row_d  = row_q + One;
          end
        end
        HEAD_DOWN: begin
          if (row_q < bot_q) begin
            row_d = row_q + One;
          end else begin
            right_d = right_q - One;
            head_d  = HEAD_LEFT;
            col_d   = col_q - One;
          end
        end
        HEAD_LEFT: begin
          if (col_q > left_q) begin
            col_d = col_q - One;
          end else begin
            bot_d  = bot_q - One;
            head_d = HEAD_UP;
            row_d  = row_q - One;
          end
        end
        default: begin
          if (row_q > top_q) begin
            row_d = row_q - One;
          end else begin
            left_d = left_q + One;
            head_d = HEAD_RIGHT;
            col_d  = col_q + One;
          end
        end
      endcase
    end
  end

  // reset matches a 1 x 1 matrix, the reset register values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      bot_q       <= '0;
      left_q      <= '0;
      right_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      head_q      <= HEAD_RIGHT;
      rows_used_q <= One;
      cols_used_q <= One;
    end else begin
      top_q       <= top_d;
      bot_q       <= bot_d;
      left_q      <= left_d;
      right_q     <= right_d;
      row_q       <= row_d;
      col_q       <= col_d;
      head_q      <= head_d;
      rows_used_q <= rows_used_d;
      cols_used_q <= cols_used_d;
    end
  end

endmodule

[rtl/spiral_order_matrix_fill.sv]
// Spiral matrix fill. Each command transaction yields exactly one result
// transaction. A push stores its value at the next cell of a clockwise
// spiral (right along the top row, down the right column, left along the
// bottom row, up the left column, then inward) and reports that cell; once
// every cell is filled a push answers placed 0 and changes nothing. A read
// returns the cell's value, or -1 if it was not written since the last
// restart or lies outside the matrix. A restart rewinds the spiral and
// forgets all written cells; it takes effect at once, with no clearing
// pass: whether a cell was written is derived from the spiral's current
// bounds and position, so only cell values live in memory. Row and column
// counts written over the config port apply at the next restart (or
// reset); 0 acts as 1 and values above MAX_ROWS or MAX_COLUMNS are capped.
// Throughput is one command per cycle while results are taken; a result
// passes from the stage-1 register, where the cell memory read completes,
// to the output register. The output register lets a new command enter while
// a result waits to be taken. Config writes are always ready.
// depends on smf_pkg, smf_if, smf_walker, smf_cell_ram

module spiral_order_matrix_fill #(
  parameter int unsigned MAX_ROWS    = 32,
  parameter int unsigned MAX_COLUMNS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  smf_in_if.sink    in_i,
  smf_out_if.source out_o,
  smf_cfg_if.sink   cfg_i
);
  import smf_pkg::*;

  localparam int unsigned MaxDim = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
  localparam int unsigned PwRaw  = $clog2(MaxDim + 1) + 1;
  // wide enough for signed bounds and 5-bit query coordinates
  localparam int unsigned PW     = (PwRaw > 6) ? PwRaw : 7;
  localparam int unsigned RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned AW     = RW + CW;

  localparam logic signed [PW-1:0] MaxRowsS = PW'(MAX_ROWS);
  localparam logic signed [PW-1:0] MaxColsS = PW'(MAX_COLUMNS);

  // config registers
  logic [CfgW-1:0] row_count_q, column_count_q;
  logic            cfg_accept;

  assign cfg_i.ready = 1'b1;
  assign cfg_accept  = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CfgW'(1);
      column_count_q <= CfgW'(1);
    end else if (cfg_accept) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ROW_COUNT:    row_count_q    <= cfg_i.data;
        CFG_COLUMN_COUNT: column_count_q <= cfg_i.data;
        default:          ;
      endcase
    end
  end

  // clamped dimensions used at restart
  logic signed [PW-1:0] rows_eff, cols_eff;

  always_comb begin
    rows_eff = PW'(row_count_q);
    if (row_count_q == '0) begin
      rows_eff = PW'(1);
    end else if (PW'(row_count_q) > MaxRowsS) begin
      rows_eff = MaxRowsS;
    end
    cols_eff = PW'(column_count_q);
    if (column_count_q == '0) begin
      cols_eff = PW'(1);
    end else if (PW'(column_count_q) > MaxColsS) begin
      cols_eff = MaxColsS;
    end
  end

  // command decode
  logic                 in_accept, s1_adv;
  logic                 s1_valid_q;
  op_e                  op;
  walk_cmd_t            walk_cmd;
  walk_status_t         walk_status;
  logic signed [PW-1:0] cur_row, cur_col;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        waddr, raddr;
  logic [ValueW-1:0]    rdata;

  assign s1_adv     = s1_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_accept  = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.op);

  assign walk_cmd.restart = in_accept && (op == OP_RESTART);
  assign walk_cmd.step    = in_accept && (op == OP_PUSH) && walk_status.can_place;

  smf_walker #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .PW          (PW)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (walk_cmd),
    .rows_i      (rows_eff),
    .cols_i      (cols_eff),
    .query_row_i (in_i.read_row),
    .query_col_i (in_i.read_column),
    .status_o    (walk_status),
    .cur_row_o   (cur_row),
    .cur_col_o   (cur_col)
  );

  // memory is written at the push's acceptance; reads see all earlier pushes
  assign mem_we = walk_cmd.step;
  assign waddr  = {RW'(cur_row), CW'(cur_col)};
  assign mem_re = in_accept && (op == OP_READ) && walk_status.query_hit;
  assign raddr  = {RW'(in_i.read_row), CW'(in_i.read_column)};

  smf_cell_ram #(
    .AW (AW),
    .DW (ValueW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (in_i.push_value),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // stage 1: result fields while the memory read completes
  logic              s1_placed_q, s1_placed_d, s1_from_mem_q, s1_from_mem_d;
  logic [FieldW-1:0] s1_row_q, s1_row_d, s1_col_q, s1_col_d;
  logic [ValueW-1:0] s1_value_q, s1_value_d;

  always_comb begin
    s1_placed_d   = 1'b0;
    s1_from_mem_d = 1'b0;
    s1_row_d      = '0;
    s1_col_d      = '0;
    s1_value_d    = '0;
    case (op)
      OP_PUSH: begin
        if (walk_status.can_place) begin
          s1_placed_d = 1'b1;
          s1_row_d    = cur_row[FieldW-1:0];
          s1_col_d    = cur_col[FieldW-1:0];
          s1_value_d  = in_i.push_value;
        end
      end
      OP_READ: begin
        s1_from_mem_d = walk_status.query_hit;
        s1_value_d    = '1;  // -1 for a cell never written
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_placed_q   <= s1_placed_d;
      s1_from_mem_q <= s1_from_mem_d;
      s1_row_q      <= s1_row_d;
      s1_col_q      <= s1_col_d;
      s1_value_q    <= s1_value_d;
    end
  end

  // output register
  logic              out_valid_q;
  logic              out_placed_q;
  logic [FieldW-1:0] out_row_q, out_col_q;
  logic [ValueW-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // read data holds until the next read, which cannot start before stage 1 moves on
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_placed_q <= s1_placed_q;
      out_row_q    <= s1_row_q;
      out_col_q    <= s1_col_q;
      out_value_q  <= s1_from_mem_q ? rdata : s1_value_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.placed        = out_placed_q;
  assign out_o.placed_row    = out_row_q;
  assign out_o.placed_column = out_col_q;
  assign out_o.cell_value    = out_value_q;

endmodule
